/* hdl/mhcc_pkg.sv */
// ----------------------------------------------------------------------------
// mhcc_pkg
// Shared constants for the multiplicative hash clash checker: data widths,
// result field widths, the configuration register map and the item codes.
// ----------------------------------------------------------------------------
package mhcc_pkg;

  // Data path widths.
  localparam int MulW  = 64;
  localparam int HalfW = 32;

  // Result field widths.
  localparam int SlotOutW  = 16;
  localparam int EntryOutW = 14;

  // Width of the trial tag kept beside each slot value.
  localparam int EpochW = 8;

  // Depth of the queue between the front and the back.
  localparam int QueueDepth = 4;

  // Defaults of the top level parameters.
  localparam int DefaultMaxIndexBits = 16;
  localparam int DefaultMaxEntries   = 16384;

  // Configuration port.
  localparam int ApbDataW  = 32;
  localparam int PaddrW    = 3;
  localparam int IndexCfgW = 5;
  localparam logic [IndexCfgW-1:0] IndexBitsReset = 5'd12;

  // Register index, taken from the word address.
  localparam logic RegIndexBits = 1'b0;

  // Item codes carried in the mode field.
  localparam logic ModeBegin = 1'b0;
  localparam logic ModeEntry = 1'b1;

endpackage

/* hdl/mhcc_front.sv */
// ----------------------------------------------------------------------------
// mhcc_front
// Accepts items, keeps the multiplier of the current trial and computes the
// slot index of each entry through a two-stage split 64-bit multiplier.
// ----------------------------------------------------------------------------
module mhcc_front #(
  parameter int MaxIndexBits = mhcc_pkg::DefaultMaxIndexBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   mode_i,
  input  logic [mhcc_pkg::MulW-1:0]              multiplier_i,
  input  logic [mhcc_pkg::MulW-1:0]              occupancy_i,
  input  logic [mhcc_pkg::MulW-1:0]              attack_set_i,
  input  logic                                   last_entry_i,
  input  logic [mhcc_pkg::IndexCfgW-1:0]         index_bits_i,
  input  logic                                   sweep_busy_i,
  output logic                                   push_valid_o,
  input  logic                                   push_ready_i,
  output logic [2+MaxIndexBits+mhcc_pkg::MulW-1:0] push_data_o
);
  import mhcc_pkg::*;

  localparam logic [IndexCfgW-1:0] MaxBitsC = IndexCfgW'(MaxIndexBits);

  logic             accept;
  logic             s1_ready, s2_ready;
  logic [MulW-1:0]  mult_q;

  logic             s1_v_q, s1_mode_q, s1_last_q;
  logic [MulW-1:0]  s1_data_q, s1_pp_ll_q;
  logic [HalfW-1:0] s1_pp_hl_q, s1_pp_lh_q;

  logic             s2_v_q, s2_mode_q, s2_last_q;
  logic [MulW-1:0]  s2_data_q, s2_prod_q;

  logic [IndexCfgW-1:0] used_bits;
  logic [6:0]           shamt;
  logic [MulW-1:0]      shifted;

  // Handshake: the pipeline moves whenever the stage ahead has room.
  assign s2_ready   = !s2_v_q || push_ready_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready || sweep_busy_i;
  assign accept     = in_valid_i && !in_stall_o;

  // A begin item replaces the multiplier for every entry after it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= '0;
    end else if (accept && mode_i == ModeBegin) begin
      mult_q <= multiplier_i;
    end
  end

  // Stage one: the three 32-bit partial products that reach the low word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= mode_i;
      s1_last_q  <= last_entry_i;
      s1_data_q  <= (mode_i == ModeBegin) ? multiplier_i : attack_set_i;
      s1_pp_ll_q <= occupancy_i[HalfW-1:0] * mult_q[HalfW-1:0];
      s1_pp_hl_q <= occupancy_i[MulW-1:HalfW] * mult_q[HalfW-1:0];
      s1_pp_lh_q <= occupancy_i[HalfW-1:0] * mult_q[MulW-1:HalfW];
    end
  end

  // Stage two: the low 64 bits of the product.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ready) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_mode_q <= s1_mode_q;
      s2_last_q <= s1_last_q;
      s2_data_q <= s1_data_q;
      s2_prod_q <= s1_pp_ll_q + {s1_pp_hl_q + s1_pp_lh_q, {HalfW{1'b0}}};
    end
  end

  // Slot index: the top bits of the product, with the width clamped.
  always_comb begin
    used_bits = index_bits_i;
    if (used_bits == '0) begin
      used_bits = IndexCfgW'(1);
    end
    if (used_bits > MaxBitsC) begin
      used_bits = MaxBitsC;
    end
    shamt   = 7'(MulW) - 7'(used_bits);
    shifted = s2_prod_q >> shamt;
  end

  assign push_valid_o = s2_v_q;
  assign push_data_o  = {s2_mode_q, s2_last_q, shifted[MaxIndexBits-1:0], s2_data_q};

endmodule

/* hdl/mhcc_queue.sv */
// ----------------------------------------------------------------------------
// mhcc_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mhcc_queue #(
  parameter int Width = 82
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o
);
  import mhcc_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] store_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = store_q[rptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage of the queued items.
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/mhcc_back.sv */
// ----------------------------------------------------------------------------
// mhcc_back
// Carries out queued items: keeps the slot store with a trial tag per slot,
// checks each entry against its slot, records the first clash of a trial
// and delivers the result item through an output register.
// ----------------------------------------------------------------------------
module mhcc_back #(
  parameter int MaxIndexBits = mhcc_pkg::DefaultMaxIndexBits,
  parameter int MaxEntries   = mhcc_pkg::DefaultMaxEntries
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       q_valid_i,
  input  logic [2+MaxIndexBits+mhcc_pkg::MulW-1:0]   q_data_i,
  output logic                                       q_pop_o,
  output logic                                       sweep_busy_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic                                       trial_ok_o,
  output logic [mhcc_pkg::SlotOutW-1:0]              clash_slot_o,
  output logic [mhcc_pkg::EntryOutW-1:0]             clash_entry_o,
  output logic [mhcc_pkg::MulW-1:0]                  tried_multiplier_o
);
  import mhcc_pkg::*;

  localparam int SlotCount = 1 << MaxIndexBits;
  localparam int CntW      = $clog2(MaxEntries);
  localparam int ItemW     = 2 + MaxIndexBits + MulW;
  localparam int WordW     = EpochW + MulW;
  localparam logic [EpochW-1:0] EpochMax = '1;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_FINISH = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [MaxIndexBits-1:0] clr_addr_q, clr_addr_d;
  logic [EpochW-1:0]       epoch_q, epoch_d;
  logic [MulW-1:0]         cur_mult_q, cur_mult_d;
  logic                    clash_q, clash_d;
  logic [MaxIndexBits-1:0] clash_slot_q, clash_slot_d;
  logic [CntW-1:0]         clash_entry_q, clash_entry_d;
  logic [CntW-1:0]         cnt_q, cnt_d, cnt_inc;

  logic [MaxIndexBits-1:0] w_slot_q;
  logic [MulW-1:0]         w_value_q;
  logic                    w_last_q;

  logic [WordW-1:0]        mem_q [SlotCount];
  logic [WordW-1:0]        rd_q;
  logic                    mem_we;
  logic [MaxIndexBits-1:0] mem_wa;
  logic [WordW-1:0]        mem_wd;
  logic                    hit;

  logic                    out_valid_q, out_load, out_free;
  logic                    out_ok_q;
  logic [SlotOutW-1:0]     out_slot_q;
  logic [EntryOutW-1:0]    out_entry_q;
  logic [MulW-1:0]         out_mult_q;
  logic [31:0]             slot_wide, entry_wide;

  logic                    h_mode, h_last;
  logic [MaxIndexBits-1:0] h_slot;
  logic [MulW-1:0]         h_data;

  // Fields of the item at the head of the queue.
  assign h_mode = q_data_i[ItemW-1];
  assign h_last = q_data_i[ItemW-2];
  assign h_slot = q_data_i[MulW +: MaxIndexBits];
  assign h_data = q_data_i[MulW-1:0];

  assign q_pop_o      = (state_q == ST_IDLE) && q_valid_i;
  assign sweep_busy_o = (state_q == ST_CLEAR);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign cnt_inc      = (cnt_q == CntW'(MaxEntries - 1)) ? '0 : cnt_q + 1'b1;
  assign hit          = rd_q[WordW-1:MulW] == epoch_q;
  assign slot_wide    = 32'(clash_slot_q);
  assign entry_wide   = 32'(clash_entry_q);

  // Sequencer: one item at a time, a slot probe takes a read and a check.
  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    epoch_d       = epoch_q;
    cur_mult_d    = cur_mult_q;
    clash_d       = clash_q;
    clash_slot_d  = clash_slot_q;
    clash_entry_d = clash_entry_q;
    cnt_d         = cnt_q;
    out_load      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          epoch_d = EpochW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (h_mode == ModeBegin) begin
            // New trial: fresh multiplier, empty slots, clean record.
            cur_mult_d    = h_data;
            clash_d       = 1'b0;
            clash_slot_d  = '0;
            clash_entry_d = '0;
            cnt_d         = '0;
            if (epoch_q == EpochMax) begin
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end else if (clash_q) begin
            // The trial has failed already; only count the entry.
            cnt_d = cnt_inc;
            if (h_last) begin
              state_d = ST_FINISH;
            end
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (hit && rd_q[MulW-1:0] != w_value_q) begin
          clash_d       = 1'b1;
          clash_slot_d  = w_slot_q;
          clash_entry_d = cnt_q;
        end
        cnt_d   = cnt_inc;
        state_d = w_last_q ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (out_free) begin
          // Hand the result over and close the trial; the multiplier stays.
          out_load      = 1'b1;
          clash_d       = 1'b0;
          clash_slot_d  = '0;
          clash_entry_d = '0;
          cnt_d         = '0;
          if (epoch_q == EpochMax) begin
            clr_addr_d = '0;
            state_d    = ST_CLEAR;
          end else begin
            epoch_d = epoch_q + 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_addr_q    <= '0;
      epoch_q       <= EpochW'(1);
      cur_mult_q    <= '0;
      clash_q       <= 1'b0;
      clash_slot_q  <= '0;
      clash_entry_q <= '0;
      cnt_q         <= '0;
    end else begin
      state_q       <= state_d;
      clr_addr_q    <= clr_addr_d;
      epoch_q       <= epoch_d;
      cur_mult_q    <= cur_mult_d;
      clash_q       <= clash_d;
      clash_slot_q  <= clash_slot_d;
      clash_entry_q <= clash_entry_d;
      cnt_q         <= cnt_d;
    end
  end

  // The entry under test while its slot is being read.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      w_slot_q  <= h_slot;
      w_value_q <= h_data;
      w_last_q  <= h_last;
    end
  end

  // Slot store write: the clearing sweep, or a first value in an empty slot.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = w_slot_q;
    mem_wd = {epoch_q, w_value_q};
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_q;
      mem_wd = '0;
    end else if (state_q == ST_CHECK && !hit) begin
      mem_we = 1'b1;
    end
  end

  // Slot store: tag and value in one word, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[h_slot];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ok_q    <= !clash_q;
      out_slot_q  <= slot_wide[SlotOutW-1:0];
      out_entry_q <= entry_wide[EntryOutW-1:0];
      out_mult_q  <= cur_mult_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign trial_ok_o         = out_ok_q;
  assign clash_slot_o       = out_slot_q;
  assign clash_entry_o      = out_entry_q;
  assign tried_multiplier_o = out_mult_q;

endmodule

/* hdl/multiplicative_hash_clash_check.sv */
// ----------------------------------------------------------------------------
// multiplicative_hash_clash_check
// Checks a candidate multiplier against a stream of key/value entries.
// ----------------------------------------------------------------------------
// A begin item (mode 0) loads a multiplier and opens a trial; each entry
// item (mode 1) hashes its occupancy key to the top index_bits bits of the
// low 64 bits of key times multiplier and stores or compares its attack set
// in that slot. The entry flagged last delivers one result item with the
// pass flag, the first clash slot and entry number, and the multiplier.
// The front accepts one item per cycle while in_stall_o is low, into a
// two-stage multiplier and a four-item queue. The back takes one item at
// a time: begin items and entries after a clash are done in the idle state;
// a probing entry has a registered slot store read in the idle state, then
// compare and any write in the check state; the finish state hands over a
// trial's result. Slots carry an 8-bit trial tag, so opening a trial is
// free; after reset and every 255 trial openings and closings, a sweep of
// all 2^MAX_INDEX_BITS slots (65536 by default) clears tags, no item accepted.
// index_bits lives at address 0 of the configuration port.
// ----------------------------------------------------------------------------
module multiplicative_hash_clash_check #(
  parameter int MaxIndexBits = mhcc_pkg::DefaultMaxIndexBits,
  parameter int MaxEntries   = mhcc_pkg::DefaultMaxEntries
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mhcc_pkg::PaddrW-1:0]       paddr,
  input  logic [mhcc_pkg::ApbDataW-1:0]     pwdata,
  output logic [mhcc_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  // Input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [mhcc_pkg::MulW-1:0]         multiplier_i,
  input  logic [mhcc_pkg::MulW-1:0]         occupancy_i,
  input  logic [mhcc_pkg::MulW-1:0]         attack_set_i,
  input  logic                              last_entry_i,
  // Result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              trial_ok_o,
  output logic [mhcc_pkg::SlotOutW-1:0]     clash_slot_o,
  output logic [mhcc_pkg::EntryOutW-1:0]    clash_entry_o,
  output logic [mhcc_pkg::MulW-1:0]         tried_multiplier_o
);
  import mhcc_pkg::*;

  localparam int ItemW = 2 + MaxIndexBits + MulW;

  logic [IndexCfgW-1:0] index_bits_q;
  logic                 reg_sel;
  logic                 push_valid, push_ready, pop_valid, pop;
  logic [ItemW-1:0]     push_data, pop_data;
  logic                 sweep_busy;

  // Configuration register: written in the access phase of a write.
  assign pready  = 1'b1;
  assign reg_sel = paddr[PaddrW-1] == RegIndexBits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_bits_q <= IndexBitsReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      index_bits_q <= pwdata[IndexCfgW-1:0];
    end
  end

  assign prdata = reg_sel ? ApbDataW'(index_bits_q) : '0;

  // Front: accept, classify and hash.
  mhcc_front #(
    .MaxIndexBits(MaxIndexBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .multiplier_i (multiplier_i),
    .occupancy_i  (occupancy_i),
    .attack_set_i (attack_set_i),
    .last_entry_i (last_entry_i),
    .index_bits_i (index_bits_q),
    .sweep_busy_i (sweep_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Queue between the two halves.
  mhcc_queue #(
    .Width(ItemW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  // Back: slot store, clash record and result.
  mhcc_back #(
    .MaxIndexBits(MaxIndexBits),
    .MaxEntries  (MaxEntries)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (pop_valid),
    .q_data_i           (pop_data),
    .q_pop_o            (pop),
    .sweep_busy_o       (sweep_busy),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .trial_ok_o         (trial_ok_o),
    .clash_slot_o       (clash_slot_o),
    .clash_entry_o      (clash_entry_o),
    .tried_multiplier_o (tried_multiplier_o)
  );

endmodule
